[rtl/mecanum_odometry_update_macros.svh]
// assertion macros for the mecanum odometry block
`ifndef MECANUM_ODOMETRY_UPDATE_MACROS_SVH
`define MECANUM_ODOMETRY_UPDATE_MACROS_SVH

// same-cycle implication on clk, off during reset
`define MOU_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mecanum odometry assertion failed");

// next-cycle implication on clk, off during reset
`define MOU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mecanum odometry assertion failed");

`endif

[rtl/mou_pkg.sv]
// types and constants for the mecanum odometry block
`default_nettype none

package mou_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_DIV,
		S_TRIG,
		S_ROT,
		S_OUT
	} state_t;

	// register map, indexed by paddr[2]
	localparam logic REG_DPP     = 1'b0;
	localparam logic REG_MIN_INT = 1'b1;

	localparam logic [23:0] DPP_RESET     = 24'd0;
	localparam logic [15:0] MIN_INT_RESET = 16'd100;
	localparam int          DPP_W         = 24;

	// quarter-wave sine polynomial
	localparam logic [15:0] SIN_K1     = 16'd1160;
	localparam logic [15:0] SIN_K2     = 16'd10512;
	localparam logic [15:0] SIN_K3     = 16'd25736;
	localparam logic [14:0] QUARTER    = 15'd16384;
	localparam logic [17:0] Q15_MAX    = 18'd32767;
	localparam logic [15:0] COS_OFFSET = 16'h4000;
	localparam logic [49:0] ROUND_HALF = 50'd16384;

	// sine sub-steps
	localparam logic [2:0] TS_ZZ  = 3'd0;
	localparam logic [2:0] TS_Z2  = 3'd1;
	localparam logic [2:0] TS_C1  = 3'd2;
	localparam logic [2:0] TS_T1  = 3'd3;
	localparam logic [2:0] TS_TZ2 = 3'd4;
	localparam logic [2:0] TS_T2  = 3'd5;
	localparam logic [2:0] TS_TZ  = 3'd6;
	localparam logic [2:0] TS_V   = 3'd7;
	localparam logic [3:0] TRIG_LAST = 4'd15;

	// rotation steps
	localparam logic [2:0] RT_SXC = 3'd0;
	localparam logic [2:0] RT_SYS = 3'd1;
	localparam logic [2:0] RT_SXS = 3'd2;
	localparam logic [2:0] RT_SYC = 3'd3;
	localparam logic [2:0] RT_ADD = 3'd4;
	localparam logic [2:0] RT_RND = 3'd5;
	localparam logic [2:0] RT_ACC = 3'd6;

endpackage

`default_nettype wire

[rtl/mecanum_odometry_update.sv]
// mecanum wheel odometry: bit-serial scaling and division, shared multiplier for trig and rotation
// an updating request is taken only once the previous one is through the 24-step serial
//   multiply, the (COUNTER_BITS + 26)-step restoring divide, 23 steps on the shared multiplier and output
// a request inside the minimum interval is accepted in S_IDLE and yields no result
// reset clears positions, previous counts and time, and loads the register reset values
`default_nettype none
`include "mecanum_odometry_update_macros.svh"

module mecanum_odometry_update #(
	parameter int COUNTER_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic [15:0]        count_front_left,
	input  logic [15:0]        count_front_right,
	input  logic [15:0]        count_rear_left,
	input  logic [15:0]        count_rear_right,
	input  logic               dir_front_left,
	input  logic               dir_front_right,
	input  logic               dir_rear_left,
	input  logic               dir_rear_right,
	input  logic [31:0]        time_ms,
	input  logic signed [15:0] heading,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] speed_front_left,
	output logic signed [31:0] speed_front_right,
	output logic signed [31:0] speed_rear_left,
	output logic signed [31:0] speed_rear_right,
	output logic signed [31:0] velocity_forward,
	output logic signed [31:0] velocity_lateral,
	output logic signed [31:0] position_x,
	output logic signed [31:0] position_y
);
	import mou_pkg::*;

	localparam int CB = COUNTER_BITS;
	localparam int PW = CB + DPP_W;
	localparam int WD = PW + 2;
	localparam int SW = PW + 3;
	localparam int CW = $clog2(WD + 1);

	localparam logic signed [CB+1:0] HALF_D = {3'b001, {(CB-1){1'b0}}};
	localparam logic signed [CB+1:0] FULL_D = {2'b01, {CB{1'b0}}};
	localparam logic signed [SW-1:0] S_MAX  = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] S_MIN  = SW'(-64'sd2147483648);
	localparam logic signed [35:0]   A_MAX  = 36'sd2147483647;
	localparam logic signed [35:0]   A_MIN  = -36'sd2147483648;

	function automatic logic signed [31:0] spd_sat(input logic [WD-1:0] q, input logic n);
		logic signed [31:0] r;
		if (!n) begin
			r = (q > WD'(33'h07fffffff)) ? 32'sh7fffffff : $signed(q[31:0]);
		end else begin
			r = (q > WD'(33'h080000000)) ? 32'sh80000000 : -$signed(q[31:0]);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sum_scale(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		logic signed [31:0] r;
		t = (v + ((v < 0) ? SW'(1023) : SW'(0))) >>> 10;
		if (t > S_MAX) begin
			r = 32'sh7fffffff;
		end else if (t < S_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = t[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [34:0] round_q15(input logic signed [49:0] v);
		logic [49:0] m;
		logic [49:0] r;
		logic signed [34:0] o;
		m = (v < 0) ? 50'(-v) : 50'(v);
		r = (m + ROUND_HALF) >> 15;
		o = (v < 0) ? -$signed(r[34:0]) : $signed(r[34:0]);
		return o;
	endfunction

	function automatic logic signed [31:0] acc_sat(input logic signed [31:0] a,
			input logic signed [34:0] d);
		logic signed [35:0] s;
		logic signed [31:0] r;
		s = {{4{a[31]}}, a} + {d[34], d};
		if (s > A_MAX) begin
			r = 32'sh7fffffff;
		end else if (s < A_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	state_t state_q, state_d;

	logic [23:0]        dpp_q;
	logic [15:0]        min_int_q;
	logic [CB-1:0]      prev_q [4];
	logic [31:0]        prev_time_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic               result_valid_q;

	logic [31:0]        dt_q;
	logic [15:0]        heading_q;
	logic [3:0]         neg_q;
	logic [PW-1:0]      mcand_q [4];
	logic [PW-1:0]      prod_q [4];
	logic [23:0]        dpp_sh_q;
	logic [WD-1:0]      dvd_q [4];
	logic [32:0]        rem_q [4];
	logic [CW-1:0]      cnt_q;
	logic [3:0]         trig_q;
	logic [2:0]         rot_q;
	logic signed [SW-1:0] sumx_q, sumy_q;
	logic signed [31:0] sx_q, sy_q;
	logic signed [31:0] spd_q [4];
	logic signed [49:0] mul_q;
	logic [14:0]        z2_q;
	logic [15:0]        t_q;
	logic signed [15:0] sin_q, cos_q;
	logic signed [49:0] rx_q, ry_q;
	logic signed [34:0] dx_q, dy_q;
	logic signed [31:0] o_spd_q [4];
	logic signed [31:0] o_vx_q, o_vy_q, o_px_q, o_py_q;

	logic               accept, short_int, update, out_load, cfg_wr;
	logic [31:0]        dt_now;
	logic [15:0]        min_eff;
	logic [15:0]        cnt_in [4];
	logic [3:0]         dir_in;
	logic [CB+15:0]     cur_ext [4];
	logic [CB-1:0]      cur [4];
	logic signed [CB+1:0] raw [4];
	logic signed [CB+1:0] fold [4];
	logic signed [CB+1:0] sdel [4];
	logic signed [CB+1:0] adel [4];
	logic [3:0]         neg_in;
	logic [PW+6:0]      n125 [4];
	logic signed [SW-1:0] sd [4];
	logic [32:0]        rsh [4];
	logic [3:0]         ge;
	logic [15:0]        ang;
	logic [14:0]        zval;
	logic               zneg;
	logic [17:0]        vraw;
	logic [15:0]        vclamp;
	logic signed [15:0] vsgn;
	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_p;
	logic signed [33:0] vx_sum, vy_sum;
	logic signed [33:0] vx_t, vy_t;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_DPP) ? {8'd0, dpp_q} : {16'd0, min_int_q};

	assign cnt_in[0] = count_front_left;
	assign cnt_in[1] = count_front_right;
	assign cnt_in[2] = count_rear_left;
	assign cnt_in[3] = count_rear_right;
	assign dir_in    = {dir_rear_right, dir_rear_left, dir_front_right, dir_front_left};

	assign dt_now    = time_ms - prev_time_q;
	assign min_eff   = (min_int_q == 16'd0) ? 16'd1 : min_int_q;
	assign short_int = dt_now < {16'd0, min_eff};

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cur_ext[i] = {{CB{1'b0}}, cnt_in[i]};
			cur[i]     = cur_ext[i][CB-1:0];
			raw[i]     = $signed({2'b00, cur[i]}) - $signed({2'b00, prev_q[i]});
			if (raw[i] > HALF_D) begin
				fold[i] = raw[i] - FULL_D;
			end else if (raw[i] < -HALF_D) begin
				fold[i] = raw[i] + FULL_D;
			end else begin
				fold[i] = raw[i];
			end
			sdel[i]   = dir_in[i] ? fold[i] : -fold[i];
			neg_in[i] = sdel[i][CB+1];
			adel[i]   = neg_in[i] ? -sdel[i] : sdel[i];
			n125[i]   = {prod_q[i], 7'd0} - {6'd0, prod_q[i], 1'd0} - {7'd0, prod_q[i]};
			sd[i]     = neg_q[i] ? -$signed({3'b000, prod_q[i]}) : $signed({3'b000, prod_q[i]});
			rsh[i]    = {rem_q[i][31:0], dvd_q[i][WD-1]};
			ge[i]     = rsh[i] >= {1'b0, dt_q};
		end
	end

	// angle folding into the first quadrant, and clamp and sign of the sine result
	always_comb begin
		ang    = trig_q[3] ? heading_q + COS_OFFSET : heading_q;
		zval   = ang[14] ? QUARTER - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
		zneg   = ang[15];
		vraw   = {mul_q[30:14], 1'b0};
		vclamp = (vraw > Q15_MAX) ? Q15_MAX[15:0] : vraw[15:0];
		vsgn   = zneg ? -$signed(vclamp) : $signed(vclamp);
	end

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_TRIG) begin
			case (trig_q[2:0])
				TS_ZZ: begin
					mul_a = {18'd0, zval};
					mul_b = {2'd0, zval};
				end
				TS_C1: begin
					mul_a = {17'd0, SIN_K1};
					mul_b = {2'd0, z2_q};
				end
				TS_TZ2: begin
					mul_a = {17'd0, t_q};
					mul_b = {2'd0, z2_q};
				end
				TS_TZ: begin
					mul_a = {17'd0, t_q};
					mul_b = {2'd0, zval};
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else if (state_q == S_ROT) begin
			case (rot_q)
				RT_SXC: begin
					mul_a = {sx_q[31], sx_q};
					mul_b = {cos_q[15], cos_q};
				end
				RT_SYS: begin
					mul_a = {sy_q[31], sy_q};
					mul_b = {sin_q[15], sin_q};
				end
				RT_SXS: begin
					mul_a = {sx_q[31], sx_q};
					mul_b = {sin_q[15], sin_q};
				end
				RT_SYC: begin
					mul_a = {sy_q[31], sy_q};
					mul_b = {cos_q[15], cos_q};
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		vx_sum = 34'(spd_q[0]) + 34'(spd_q[1]) + 34'(spd_q[2]) + 34'(spd_q[3]);
		vy_sum = -34'(spd_q[0]) + 34'(spd_q[1]) + 34'(spd_q[2]) - 34'(spd_q[3]);
		vx_t   = (vx_sum + ((vx_sum < 0) ? 34'sd3 : 34'sd0)) >>> 2;
		vy_t   = (vy_sum + ((vy_sum < 0) ? 34'sd3 : 34'sd0)) >>> 2;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !short_int) state_d = S_MUL;
			end
			S_MUL: begin
				if (cnt_q == CW'(DPP_W - 1)) state_d = S_SUM;
			end
			S_SUM: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (cnt_q == CW'(WD - 1)) state_d = S_TRIG;
			end
			S_TRIG: begin
				if (trig_q == TRIG_LAST) state_d = S_ROT;
			end
			S_ROT: begin
				if (rot_q == RT_ACC) state_d = S_OUT;
			end
			S_OUT: begin
				if (!result_valid_q || result_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// handshake and control outputs
	always_comb begin
		sample_ready = (state_q == S_IDLE);
		accept       = sample_valid && sample_ready;
		update       = accept && !short_int;
		out_load     = (state_q == S_OUT) && (!result_valid_q || result_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			dpp_q          <= DPP_RESET;
			min_int_q      <= MIN_INT_RESET;
			prev_time_q    <= '0;
			acc_x_q        <= '0;
			acc_y_q        <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				if (paddr[2] == REG_DPP) begin
					dpp_q <= pwdata[23:0];
				end else begin
					min_int_q <= pwdata[15:0];
				end
			end
			if (update) begin
				prev_time_q <= time_ms;
				for (int i = 0; i < 4; i++) begin
					prev_q[i] <= cur[i];
				end
			end
			if (state_q == S_ROT && rot_q == RT_ACC) begin
				acc_x_q <= acc_sat(acc_x_q, dx_q);
				acc_y_q <= acc_sat(acc_y_q, dy_q);
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		case (state_q)
			S_IDLE: begin
				if (update) begin
					dt_q      <= dt_now;
					heading_q <= heading;
					dpp_sh_q  <= dpp_q;
					cnt_q     <= '0;
					trig_q    <= '0;
					rot_q     <= '0;
					neg_q     <= neg_in;
					for (int i = 0; i < 4; i++) begin
						mcand_q[i] <= {{DPP_W{1'b0}}, adel[i][CB-1:0]};
						prod_q[i]  <= '0;
					end
				end
			end
			S_MUL: begin
				for (int i = 0; i < 4; i++) begin
					if (dpp_sh_q[0]) prod_q[i] <= prod_q[i] + mcand_q[i];
					mcand_q[i] <= {mcand_q[i][PW-2:0], 1'b0};
				end
				dpp_sh_q <= {1'b0, dpp_sh_q[23:1]};
				cnt_q    <= cnt_q + CW'(1);
			end
			S_SUM: begin
				sumx_q <= sd[0] + sd[1] + sd[2] + sd[3];
				sumy_q <= -sd[0] + sd[1] + sd[2] - sd[3];
				cnt_q  <= '0;
				for (int i = 0; i < 4; i++) begin
					dvd_q[i] <= n125[i][PW+6:5];
					rem_q[i] <= '0;
				end
			end
			S_DIV: begin
				for (int i = 0; i < 4; i++) begin
					rem_q[i] <= ge[i] ? rsh[i] - {1'b0, dt_q} : rsh[i];
					dvd_q[i] <= {dvd_q[i][WD-2:0], ge[i]};
				end
				cnt_q <= cnt_q + CW'(1);
			end
			S_TRIG: begin
				if (trig_q == 4'd0) begin
					sx_q <= sum_scale(sumx_q);
					sy_q <= sum_scale(sumy_q);
					for (int i = 0; i < 4; i++) begin
						spd_q[i] <= spd_sat(dvd_q[i], neg_q[i]);
					end
				end
				case (trig_q[2:0])
					TS_Z2: z2_q <= mul_q[28:14];
					TS_T1: t_q  <= SIN_K2 - mul_q[29:14];
					TS_T2: t_q  <= SIN_K3 - mul_q[29:14];
					TS_V: begin
						if (trig_q[3]) begin
							cos_q <= vsgn;
						end else begin
							sin_q <= vsgn;
						end
					end
					default: begin
						t_q <= t_q;
					end
				endcase
				trig_q <= trig_q + 4'd1;
			end
			S_ROT: begin
				case (rot_q)
					RT_SYS: rx_q <= mul_q;
					RT_SXS: rx_q <= rx_q - mul_q;
					RT_SYC: ry_q <= mul_q;
					RT_ADD: ry_q <= ry_q + mul_q;
					RT_RND: begin
						dx_q <= round_q15(rx_q);
						dy_q <= round_q15(ry_q);
					end
					default: begin
						rx_q <= rx_q;
					end
				endcase
				rot_q <= rot_q + 3'd1;
			end
			S_OUT: begin
				if (out_load) begin
					for (int i = 0; i < 4; i++) begin
						o_spd_q[i] <= spd_q[i];
					end
					o_vx_q <= vx_t[31:0];
					o_vy_q <= vy_t[31:0];
					o_px_q <= acc_x_q;
					o_py_q <= acc_y_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign result_valid      = result_valid_q;
	assign speed_front_left  = o_spd_q[0];
	assign speed_front_right = o_spd_q[1];
	assign speed_rear_left   = o_spd_q[2];
	assign speed_rear_right  = o_spd_q[3];
	assign velocity_forward  = o_vx_q;
	assign velocity_lateral  = o_vy_q;
	assign position_x        = o_px_q;
	assign position_y        = o_py_q;

	`MOU_ASSERT_NXT(a_short_interval_dropped, sample_valid && sample_ready && short_int, state_q == S_IDLE)
	`MOU_ASSERT(a_remainder_below_dt, state_q == S_DIV, rem_q[0] < {1'b0, dt_q} && rem_q[3] < {1'b0, dt_q})
	`MOU_ASSERT(a_trig_magnitude, state_q == S_ROT, sin_q != 16'sh8000 && cos_q != 16'sh8000)
	`MOU_ASSERT(a_valid_only_from_out, $rose(result_valid_q), $past(state_q) == S_OUT)

endmodule

`default_nettype wire

[dv/mecanum_odometry_update_tb.sv]
// testbench for mecanum_odometry_update: directed table then random requests, checked against a predictor
`default_nettype none

module mecanum_odometry_update_tb;
	import mou_pkg::*;

	typedef struct packed {
		logic [3:0][15:0]   cnt;  // [0] front left, [1] front right, [2] rear left, [3] rear right
		logic [3:0]         dir;
		logic [31:0]        tm;
		logic signed [15:0] hdg;
	} sample_t;

	typedef logic [7:0][31:0] odo_t;

	typedef struct packed {
		sample_t     s;
		logic        known;
		logic        emits;
		logic        wr;
		logic [23:0] dpp;
		logic [15:0] mi;
	} row_t;

	localparam int LIMIT = 2000000;
	localparam int DRAIN = 120;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic sample_valid, sample_ready;
	logic [15:0] count_front_left, count_front_right, count_rear_left, count_rear_right;
	logic dir_front_left, dir_front_right, dir_rear_left, dir_rear_right;
	logic [31:0] time_ms;
	logic signed [15:0] heading;
	logic result_valid, result_ready;
	logic signed [31:0] speed_front_left, speed_front_right, speed_rear_left, speed_rear_right;
	logic signed [31:0] velocity_forward, velocity_lateral, position_x, position_y;

	mecanum_odometry_update dut (.*);

	// predictor state
	longint unsigned     last_cnt[4];
	longint unsigned     last_tm;
	longint              pos_x, pos_y;
	longint unsigned     dpp_reg, min_reg;

	odo_t    odo_q[$];
	bit      failed;
	int      updates;
	int      cycles;
	sample_t cur;
	row_t    rows[13];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint quarter_wave(longint unsigned z);
		longint unsigned z2, t;
		z2 = (z * z) >> 14;
		t = (SIN_K1 * z2) >> 14;
		t = SIN_K2 - t;
		t = (t * z2) >> 14;
		t = SIN_K3 - t;
		t = (t * z) >> 14;
		t = t << 1;
		if (t > Q15_MAX) t = Q15_MAX;
		return longint'(t);
	endfunction

	function automatic longint sine_q15(logic [15:0] ang);
		longint unsigned r;
		longint v;
		r = ang[13:0];
		v = ang[14] ? quarter_wave(QUARTER - r) : quarter_wave(r);
		return ang[15] ? -v : v;
	endfunction

	function automatic longint round_half_away(longint v);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : v;
		m = (m + ROUND_HALF) >> 15;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic bit odometry_step(sample_t s, output odo_t r);
		longint unsigned dt, minv;
		longint d, wheel_dist[4], spd[4], sx, sy, sn, cs;
		dt = (longint'(s.tm) - last_tm) & 64'hFFFF_FFFF;
		minv = (min_reg != 0) ? min_reg : 1;
		r = '0;
		if (dt < minv) return 1'b0;
		last_tm = s.tm;
		for (int i = 0; i < 4; i++) begin
			d = longint'(s.cnt[i]) - longint'(last_cnt[i]);
			if (d > 32768) d -= 65536;
			else if (d < -32768) d += 65536;
			if (!s.dir[i]) d = -d;
			last_cnt[i] = s.cnt[i];
			wheel_dist[i] = d * longint'(dpp_reg);
			spd[i] = sat32((wheel_dist[i] * 125) / longint'(dt * 32));
			r[i] = spd[i][31:0];
		end
		r[4] = 32'(sat32((spd[0] + spd[1] + spd[2] + spd[3]) / 4));
		r[5] = 32'(sat32((-spd[0] + spd[1] + spd[2] - spd[3]) / 4));
		sx = sat32((wheel_dist[0] + wheel_dist[1] + wheel_dist[2] + wheel_dist[3]) / 1024);
		sy = sat32((-wheel_dist[0] + wheel_dist[1] + wheel_dist[2] - wheel_dist[3]) / 1024);
		sn = sine_q15(s.hdg);
		cs = sine_q15(s.hdg + COS_OFFSET);
		pos_x = sat32(pos_x + round_half_away(sx * cs - sy * sn));
		pos_y = sat32(pos_y + round_half_away(sx * sn + sy * cs));
		r[6] = pos_x[31:0];
		r[7] = pos_y[31:0];
		return 1'b1;
	endfunction

	task automatic reg_write(input logic regsel, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {regsel, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (regsel == REG_DPP) dpp_reg = v[23:0];
		else min_reg = v[15:0];
		@(posedge clk);
	endtask

	task automatic drain;
		sample_valid <= 1'b0;
		while (odo_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic configure(input logic [23:0] dpp, input logic [15:0] mi);
		drain();
		reg_write(REG_DPP, {8'd0, dpp});
		reg_write(REG_MIN_INT, {16'd0, mi});
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// drives one request and queues its expected result when one is due
	task automatic send(input sample_t s, input bit typed, input bit typed_emits);
		int g;
		odo_t r;
		bit upd;
		g = pick_gap();
		if (g > 0) begin
			sample_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		count_front_left <= s.cnt[0];
		count_front_right <= s.cnt[1];
		count_rear_left <= s.cnt[2];
		count_rear_right <= s.cnt[3];
		dir_front_left <= s.dir[0];
		dir_front_right <= s.dir[1];
		dir_rear_left <= s.dir[2];
		dir_rear_right <= s.dir[3];
		time_ms <= s.tm;
		heading <= s.hdg;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
		upd = odometry_step(s, r);
		if (typed) begin
			if (typed_emits) odo_q.push_back('0);
		end else if (upd) begin
			odo_q.push_back(r);
		end
		if (upd) updates++;
		cur = s;
	endtask

	function automatic sample_t random_sample();
		sample_t s;
		int p;
		longint unsigned step;
		s = cur;
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 9) == 0) s.cnt[i] = 16'($urandom);
			else s.cnt[i] = cur.cnt[i] + 16'($urandom_range(0, 4000)) - 16'd2000;
		end
		s.dir = 4'($urandom);
		s.hdg = 16'($urandom);
		p = $urandom_range(0, 99);
		if (p < 85) step = min_reg + $urandom_range(0, 3 * ((min_reg != 0) ? min_reg : 1));
		else if (p < 95) step = (min_reg > 1) ? $urandom_range(0, min_reg - 1) : 0;
		else step = $urandom;
		s.tm = cur.tm + 32'(step);
		return s;
	endfunction

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int hold;
		bit rdy;
		result_ready = 1'b0;
		hold = 0;
		rdy = 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				rdy = ($urandom_range(0, 9) < 6);
				if (rdy) hold = $urandom_range(1, 20);
				else hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			end
			hold--;
			result_ready <= rdy;
		end
	end

	always @(posedge clk) begin
		odo_t e, a;
		if (arst_n && result_valid && result_ready) begin
			a = {position_y, position_x, velocity_lateral, velocity_forward,
				speed_rear_right, speed_rear_left, speed_front_right, speed_front_left};
			if (odo_q.size() == 0) begin
				$display("%0t unexpected result %p", $time, a);
				failed = 1'b1;
			end else begin
				e = odo_q.pop_front();
				for (int i = 0; i < 8; i++)
					if (e[i] !== a[i]) begin
						$display("%0t field %0d expected %0d actual %0d", $time, i,
							$signed(e[i]), $signed(a[i]));
						failed = 1'b1;
					end
			end
		end
	end

	initial begin
		failed = 1'b0;
		updates = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		count_front_left = '0;
		count_front_right = '0;
		count_rear_left = '0;
		count_rear_right = '0;
		dir_front_left = 1'b0;
		dir_front_right = 1'b0;
		dir_rear_left = 1'b0;
		dir_rear_right = 1'b0;
		time_ms = '0;
		heading = '0;
		cur = '0;
		for (int i = 0; i < 4; i++) last_cnt[i] = 0;
		last_tm = 0;
		pos_x = 0;
		pos_y = 0;
		dpp_reg = DPP_RESET;
		min_reg = MIN_INT_RESET;

		// cnt written rear right first; dir bit 0 is front left
		rows[0]  = '{'{{16'd4, 16'd3, 16'd2, 16'd1}, 4'b1010, 32'd50, 16'sd0}, 1, 0, 0, 0, 0};
		rows[1]  = '{'{{16'd4, 16'd3, 16'd2, 16'd1}, 4'b1010, 32'd100, 16'sd0}, 1, 1, 0, 0, 0};
		rows[2]  = '{'{{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 4'b1111, 32'd199, 16'sd5},
			1, 0, 0, 0, 0};
		rows[3]  = '{'{{16'd32772, 16'd32771, 16'd32770, 16'd32769}, 4'b1111, 32'd101, 16'sd0},
			0, 0, 1, 24'hFFFFFF, 16'd1};
		rows[4]  = '{'{{16'd4, 16'd3, 16'd2, 16'd1}, 4'b1111, 32'd102, 16'sd16384}, 0, 0, 0, 0, 0};
		rows[5]  = '{'{{16'd32773, 16'd32772, 16'd32771, 16'd32770}, 4'b0000, 32'd103, 16'sh8000},
			0, 0, 0, 0, 0};
		rows[6]  = '{'{{16'd0, 16'hFFFF, 16'd0, 16'hFFFF}, 4'b0101, 32'd1103, 16'sd32767},
			0, 0, 0, 0, 0};
		rows[7]  = '{'{{16'hFFFF, 16'd0, 16'hFFFF, 16'd0}, 4'b1010, 32'hFFFFFFFF, -16'sd16384},
			0, 0, 0, 0, 0};
		rows[8]  = '{'{{16'hFFFF, 16'd0, 16'hFFFF, 16'd0}, 4'b1010, 32'hFFFFFFFF, 16'sd0},
			1, 0, 0, 0, 0};
		rows[9]  = '{'{{16'd40, 16'd30, 16'd20, 16'd10}, 4'b0110, 32'd4, 16'sd8192}, 0, 0, 0, 0, 0};
		rows[10] = '{'{{16'd40, 16'd30, 16'd20, 16'd10}, 4'b0110, 32'd4, 16'sd8192},
			1, 0, 1, 24'hFFFFFF, 16'd0};
		rows[11] = '{'{{16'd41, 16'd31, 16'd21, 16'd11}, 4'b1001, 32'd5, -16'sd1}, 0, 0, 0, 0, 0};
		rows[12] = '{'{{16'd41, 16'd31, 16'd21, 16'd11}, 4'b1001, 32'd5, -16'sd1}, 1, 0, 0, 0, 0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (rows[k]) begin
			if (rows[k].wr) configure(rows[k].dpp, rows[k].mi);
			send(rows[k].s, rows[k].known, rows[k].emits);
		end

		for (int ph = 0; ph < 5; ph++) begin
			int target;
			case (ph)
				0: configure(24'd1, 16'hFFFF);
				1: configure(24'($urandom), 16'd1);
				2: configure(24'hFFFFFF, 16'd100);
				3: configure(24'($urandom), 16'($urandom_range(1, 2000)));
				default: configure(24'd0, 16'($urandom_range(1, 300)));
			endcase
			target = updates + 170;
			while (updates < target) send(random_sample(), 1'b0, 1'b0);
		end

		drain();
		if (!failed && odo_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/mou_pkg.sv
rtl/mecanum_odometry_update.sv
dv/mecanum_odometry_update_tb.sv
